@@ hdl/sorted_breakpoint_table_interp_core_assert.svh @@
// assertion macros shared by the breakpoint table modules
`ifndef SORTED_BREAKPOINT_TABLE_INTERP_CORE_ASSERT_SVH
`define SORTED_BREAKPOINT_TABLE_INTERP_CORE_ASSERT_SVH

// property that must hold whenever reset is released
`define SBT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// property that must hold even during reset
`define SBT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hdl/sbt_pkg.sv @@
package sbt_pkg;
    localparam int Capacity = 64;
    localparam int AddrW    = $clog2(Capacity);
    localparam int CountW   = $clog2(Capacity + 1);

    localparam logic [1:0] ACT_SET    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;
    localparam logic [1:0] ACT_LOOKUP = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // request to the divider: off * mag / span, all unsigned
    typedef struct packed {
        logic        start;
        logic [32:0] off;
        logic [32:0] mag;
        logic [32:0] span;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [65:0] quo;
    } t_div_rsp;
endpackage

@@ hdl/sorted_breakpoint_table_interp_core.sv @@
// Sorted breakpoint table with step or linear lookup. One item is taken at a
// time: a search walks the key memory one entry at a time (read, then
// compare), a set or remove then shifts entries one at a time (read, then
// write), and a linear lookup adds a multiply and divide in the bit-serial
// divider unit. The next beat is taken while a result still waits in the
// output register; its own result then waits until that beat has been taken.
module sorted_breakpoint_table_interp_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // key[31:0], entry_value[63:32], linear_mode[64]
    input  logic [1:0]  s_axis_tuser,  // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // exact_hit[0], result_value[32:1], points_held[39:33]
    output logic [1:0]  m_axis_tuser   // status[1:0]
);
    import sbt_pkg::*;

    t_div_req w_req;
    t_div_rsp w_rsp;
    logic        w_hit;
    logic [31:0] w_res;
    logic [6:0]  w_cnt;

    sbt_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_action       (s_axis_tuser),
        .i_key          (s_axis_tdata[31:0]),
        .i_entry_value  (s_axis_tdata[63:32]),
        .i_linear_mode  (s_axis_tdata[64]),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_status       (m_axis_tuser),
        .o_exact_hit    (w_hit),
        .o_result_value (w_res),
        .o_points_held  (w_cnt),
        .o_div_req      (w_req),
        .i_div_rsp      (w_rsp)
    );

    sbt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign m_axis_tdata = {w_cnt, w_res, w_hit};
endmodule

@@ hdl/sbt_div.sv @@
// shift-add multiply, then restoring division, one bit a cycle
module sbt_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sbt_pkg::t_div_req i_req,
    output sbt_pkg::t_div_rsp o_rsp
);
    import sbt_pkg::*;
    `include "sorted_breakpoint_table_interp_core_assert.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [6:0]  r_cnt, n_cnt;
    logic [65:0] r_acc, n_acc;     // product, then quotient
    logic [32:0] r_mcand, n_mcand;
    logic [32:0] r_mplier, n_mplier;
    logic [32:0] r_span, n_span;
    logic [33:0] r_rem, n_rem;
    logic [33:0] w_trial;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_span   = r_span;
        n_rem    = r_rem;
        w_trial  = {r_rem[32:0], r_acc[65]} - {1'b0, r_span};
        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_acc    = '0;
                    n_mcand  = i_req.off;
                    n_mplier = i_req.mag;
                    n_span   = i_req.span;
                    n_cnt    = 7'd33;
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                n_acc = {r_acc[64:0], 1'b0} + (r_mplier[32] ? {33'd0, r_mcand} : 66'd0);
                n_mplier = {r_mplier[31:0], 1'b0};
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    n_cnt   = 7'd66;
                    n_rem   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!w_trial[33]) begin
                    n_rem = w_trial;
                    n_acc = {r_acc[64:0], 1'b1};
                end else begin
                    n_rem = {r_rem[32:0], r_acc[65]};
                    n_acc = {r_acc[64:0], 1'b0};
                end
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_span   <= n_span;
        r_rem    <= n_rem;
    end

    assign o_rsp.done = (r_state == S_DONE);
    assign o_rsp.quo  = r_acc;

    `SBT_ASSERT(a_div_start_idle, i_req.start |-> r_state == S_IDLE, "divider started while busy")
    `SBT_ASSERT(a_div_done_once, o_rsp.done |=> !o_rsp.done, "divider done held two cycles")
    `SBT_ASSERT(a_div_cnt_live, (r_state == S_MUL || r_state == S_DIV) |-> r_cnt != 7'd0, "divider count ran out")
endmodule

@@ hdl/sbt_ctrl.sv @@
// sequencer over the key and value memories
module sbt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_action,
    input  logic [31:0]       i_key,
    input  logic [31:0]       i_entry_value,
    input  logic              i_linear_mode,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_status,
    output logic              o_exact_hit,
    output logic [31:0]       o_result_value,
    output logic [6:0]        o_points_held,
    output sbt_pkg::t_div_req o_div_req,
    input  sbt_pkg::t_div_rsp i_div_rsp
);
    import sbt_pkg::*;
    `include "sorted_breakpoint_table_interp_core_assert.svh"

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SRCH   = 4'd1;  // issue read at r_idx
    localparam logic [3:0] S_SRCHW  = 4'd2;  // compare read key
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_SHRD   = 4'd4;  // shift read
    localparam logic [3:0] S_SHWR   = 4'd5;  // shift write
    localparam logic [3:0] S_RDLO   = 4'd6;
    localparam logic [3:0] S_RDLOW  = 4'd7;
    localparam logic [3:0] S_DIVW   = 4'd8;
    localparam logic [3:0] S_RDHI   = 4'd9;
    localparam logic [3:0] S_RDVAL  = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    logic [31:0] r_key_mem [Capacity];
    logic [31:0] r_val_mem [Capacity];
    logic [31:0] r_rd_key, r_rd_val;
    logic [AddrW-1:0] w_rd_addr, w_wr_addr;
    logic        w_we;
    logic [31:0] w_wr_key, w_wr_val;

    logic [3:0]        r_state, n_state;
    logic [CountW-1:0] r_fill, n_fill;
    logic [CountW-1:0] r_idx, n_idx;   // search index: first entry not below the key
    logic [CountW-1:0] r_ptr, n_ptr;
    logic [1:0]  r_act;
    logic [31:0] r_key, r_val;
    logic        r_lin;
    logic        r_found, n_found;
    logic [31:0] r_klo, n_klo, r_vlo, n_vlo;
    logic [31:0] r_hold_k, n_hold_k, r_hold_v, n_hold_v;
    logic        r_neg, n_neg;
    logic [1:0]  r_status, n_status;
    logic        r_hit, n_hit;
    logic [31:0] r_res, n_res;
    logic        r_ovalid, n_ovalid;
    logic        w_accept;
    logic        w_load;
    logic [1:0]  r_out_status;
    logic        r_out_hit;
    logic [31:0] r_out_res;
    logic [6:0]  r_out_cnt;
    logic [32:0] w_span, w_off, w_dv;
    logic [31:0] w_quo;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    // result moves to the output register once the previous beat is gone
    assign w_load     = (r_state == S_OUT) && (!r_ovalid || i_out_ready);

    // memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_key_mem[w_wr_addr] <= w_wr_key;
            r_val_mem[w_wr_addr] <= w_wr_val;
        end
        r_rd_key <= r_key_mem[w_rd_addr];
        r_rd_val <= r_val_mem[w_rd_addr];
    end

    assign w_span = {r_rd_key[31], r_rd_key} - {r_klo[31], r_klo};
    assign w_off  = {r_key[31], r_key} - {r_klo[31], r_klo};
    assign w_dv   = {r_rd_val[31], r_rd_val} - {r_vlo[31], r_vlo};
    assign w_quo  = i_div_rsp.quo[31:0];

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_idx    = r_idx;
        n_ptr    = r_ptr;
        n_found  = r_found;
        n_klo    = r_klo;
        n_vlo    = r_vlo;
        n_hold_k = r_hold_k;
        n_hold_v = r_hold_v;
        n_neg    = r_neg;
        n_status = r_status;
        n_hit    = r_hit;
        n_res    = r_res;
        n_ovalid = r_ovalid;
        w_rd_addr = r_idx[AddrW-1:0];
        w_we      = 1'b0;
        w_wr_addr = r_ptr[AddrW-1:0];
        w_wr_key  = r_hold_k;
        w_wr_val  = r_hold_v;
        o_div_req = '0;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_idx    = '0;
                    n_ptr    = '0;
                    n_found  = 1'b0;
                    n_status = ST_OK;
                    n_hit    = 1'b0;
                    n_res    = '0;
                    n_state  = S_SRCH;
                end
            end
            S_SRCH: begin
                if (r_act == ACT_CLEAR) begin
                    n_fill  = '0;
                    n_state = S_OUT;
                end else if (r_idx >= r_fill) begin
                    n_state = S_DECIDE;
                end else begin
                    n_state = S_SRCHW;
                end
            end
            S_SRCHW: begin
                if ($signed(r_rd_key) < $signed(r_key)) begin
                    n_idx   = r_idx + CountW'(1);
                    n_state = S_SRCH;
                end else begin
                    n_found = (r_rd_key == r_key);
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_hit = r_found;
                n_state = S_OUT;
                case (r_act)
                    ACT_SET: begin
                        if (r_found) begin
                            w_we = 1'b1; w_wr_addr = r_idx[AddrW-1:0];
                            w_wr_key = r_key; w_wr_val = r_val;
                        end else if (r_fill >= CountW'(Capacity)) begin
                            n_status = ST_FULL;
                        end else begin
                            // shift up from the top, then place new point
                            n_ptr    = r_fill;
                            n_hold_k = r_key;
                            n_hold_v = r_val;
                            n_fill   = r_fill + CountW'(1);
                            n_state  = S_SHRD;
                        end
                    end
                    ACT_REMOVE: begin
                        if (r_found) begin
                            n_ptr   = r_idx;
                            n_fill  = r_fill - CountW'(1);
                            n_state = S_SHRD;
                        end else begin
                            n_status = ST_NOTFOUND;
                        end
                    end
                    default: begin
                        if (r_found) begin
                            n_idx = r_idx; n_state = S_RDVAL;
                        end else if (r_fill == '0) begin
                            n_status = ST_EMPTY;
                        end else if (r_idx == '0) begin
                            n_state = S_RDVAL;
                        end else if (r_idx >= r_fill) begin
                            n_idx = r_fill - CountW'(1); n_state = S_RDVAL;
                        end else if (!r_lin) begin
                            n_idx = r_idx - CountW'(1); n_state = S_RDVAL;
                        end else begin
                            n_state = S_RDLO;
                        end
                    end
                endcase
            end
            S_SHRD: begin
                if (r_act == ACT_SET) begin
                    if (r_ptr == r_idx) begin
                        w_we = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        w_rd_addr = AddrW'(r_ptr - CountW'(1));
                        n_state = S_SHWR;
                    end
                end else begin
                    if (r_ptr >= r_fill) begin
                        n_state = S_OUT;
                    end else begin
                        w_rd_addr = AddrW'(r_ptr + CountW'(1));
                        n_state = S_SHWR;
                    end
                end
            end
            S_SHWR: begin
                w_we = 1'b1;
                w_wr_key = r_rd_key;
                w_wr_val = r_rd_val;
                n_ptr = (r_act == ACT_SET) ? r_ptr - CountW'(1) : r_ptr + CountW'(1);
                n_state = S_SHRD;
            end
            S_RDLO: begin
                w_rd_addr = AddrW'(r_idx - CountW'(1));
                n_state = S_RDLOW;
            end
            S_RDLOW: begin
                n_klo = r_rd_key;
                n_vlo = r_rd_val;
                n_state = S_RDHI;
            end
            S_RDHI: begin
                // read data of r_idx arrives the cycle after issue
                n_state = S_DIVW;
            end
            S_DIVW: begin
                if (!i_div_rsp.done && r_ptr == '0) begin
                    o_div_req.start = 1'b1;
                    o_div_req.off   = w_off;
                    o_div_req.mag   = w_dv[32] ? -w_dv : w_dv;
                    o_div_req.span  = w_span;
                    n_neg = w_dv[32];
                    n_ptr = CountW'(1);
                end else if (i_div_rsp.done) begin
                    n_ptr = '0;
                    n_res = r_neg ? r_vlo - w_quo : r_vlo + w_quo;
                    n_state = S_OUT;
                end
            end
            S_RDVAL: begin
                n_res   = r_rd_val;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_load) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // RDVAL needs the registered read of the r_idx that DECIDE sets: the memory
    // address is r_idx, so RDVAL first issues the read, held by a wait flag, then takes the value
    logic r_rdwait;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
            r_ptr    <= '0;
            r_rdwait <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
            r_fill   <= n_fill;
            r_ptr    <= n_ptr;
            if (r_state == S_RDVAL && !r_rdwait) begin
                r_rdwait <= 1'b1;
                r_state  <= S_RDVAL;
            end else begin
                r_rdwait <= 1'b0;
                r_state  <= n_state;
            end
        end
        if (w_accept) begin
            r_act <= i_action;
            r_key <= i_key;
            r_val <= i_entry_value;
            r_lin <= i_linear_mode;
        end
        if (w_load) begin
            r_out_status <= r_status;
            r_out_hit    <= r_hit;
            r_out_res    <= r_res;
            r_out_cnt    <= 7'(r_fill);
        end
        r_idx    <= n_idx;
        r_found  <= n_found;
        r_klo    <= n_klo;
        r_vlo    <= n_vlo;
        r_hold_k <= n_hold_k;
        r_hold_v <= n_hold_v;
        r_neg    <= n_neg;
        r_status <= n_status;
        r_hit    <= n_hit;
        if (!(r_state == S_RDVAL && !r_rdwait)) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_status       = r_out_status;
    assign o_exact_hit    = r_out_hit;
    assign o_result_value = r_out_res;
    assign o_points_held  = r_out_cnt;

    `SBT_ASSERT(a_fill_max, r_fill <= CountW'(Capacity), "fill count above capacity")
    `SBT_ASSERT(a_busy_no_accept, r_state != S_IDLE |-> !o_in_ready, "ready while busy")
    `SBT_ASSERT(a_full_status, (r_ovalid && r_out_status == ST_FULL) |-> r_out_cnt == 7'(Capacity), "full status with room left")
endmodule

@@ tb/tb_sorted_breakpoint_table_interp_core.sv @@
module tb_sorted_breakpoint_table_interp_core;
    import sbt_pkg::*;

    localparam int CycleLimit = 3000000;
    localparam int RandItems  = 970;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [31:0] value;
        logic [6:0]  count;
    } t_answer;

    typedef struct {
        logic [1:0]  act;
        logic [31:0] key;
        logic [31:0] val;
        logic        lin;
        logic        known;
        t_answer     ans;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;  // key[31:0], entry_value[63:32], linear_mode[64]
    logic [1:0]  s_axis_tuser = '0;  // action[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;       // exact_hit[0], result_value[32:1], points_held[39:33]
    logic [1:0]  m_axis_tuser;       // status[1:0]

    sorted_breakpoint_table_interp_core dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor copy of the table
    logic signed [31:0] bp_key[Capacity];
    logic signed [31:0] bp_val[Capacity];
    int                 bp_fill;
    t_answer            answer_q[$];
    int                 n_fail;
    int                 cycles;
    logic               stim_done = 1'b0;

    function automatic t_answer table_step(logic [1:0] act, logic signed [31:0] key,
                                           logic signed [31:0] val, logic lin);
        t_answer a;
        int idx;
        bit found;
        longint klo, khi, vlo, vhi, dv;
        logic [63:0] span, off, mag, quo;
        a = '0;
        idx = 0;
        while (idx < bp_fill && bp_key[idx] < key) idx++;
        found = idx < bp_fill && bp_key[idx] == key;
        case (act)
            ACT_SET: begin
                if (found) begin
                    a.hit = 1'b1;
                    bp_val[idx] = val;
                end else if (bp_fill >= Capacity) begin
                    a.status = ST_FULL;
                end else begin
                    for (int j = bp_fill; j > idx; j--) begin
                        bp_key[j] = bp_key[j-1];
                        bp_val[j] = bp_val[j-1];
                    end
                    bp_key[idx] = key;
                    bp_val[idx] = val;
                    bp_fill++;
                end
            end
            ACT_REMOVE: begin
                if (found) begin
                    a.hit = 1'b1;
                    for (int j = idx; j + 1 < bp_fill; j++) begin
                        bp_key[j] = bp_key[j+1];
                        bp_val[j] = bp_val[j+1];
                    end
                    bp_fill--;
                end else begin
                    a.status = ST_NOTFOUND;
                end
            end
            ACT_CLEAR: bp_fill = 0;
            default: begin
                if (found) begin
                    a.hit = 1'b1;
                    a.value = bp_val[idx];
                end else if (bp_fill == 0) begin
                    a.status = ST_EMPTY;
                end else if (idx == 0) begin
                    a.value = bp_val[0];
                end else if (idx >= bp_fill) begin
                    a.value = bp_val[bp_fill-1];
                end else if (!lin) begin
                    a.value = bp_val[idx-1];
                end else begin
                    klo = bp_key[idx-1];
                    khi = bp_key[idx];
                    vlo = bp_val[idx-1];
                    vhi = bp_val[idx];
                    span = khi - klo;
                    off = longint'(key) - klo;
                    dv = vhi - vlo;
                    mag = dv < 0 ? -dv : dv;
                    quo = (off * mag) / span;
                    a.value = 32'(dv < 0 ? vlo - longint'(quo) : vlo + longint'(quo));
                end
            end
        endcase
        a.count = bp_fill[6:0];
        return a;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 400)) - 200) <<< $urandom_range(0, 20);
        endcase
    endfunction

    task automatic send_item(logic [1:0] act, logic [31:0] key, logic [31:0] val,
                             logic lin, logic known, t_answer ans);
        t_answer p;
        if ($urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 60)
                                               : $urandom_range(1, 3))
                @(negedge i_clk);
        end
        s_axis_tdata  <= {7'd0, lin, val, key};
        s_axis_tuser  <= act;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        p = table_step(act, key, val, lin);
        answer_q = {answer_q, (known ? ans : p)};
        @(negedge i_clk);
    endtask

    function automatic t_answer ans_of(logic [1:0] st, logic hit, logic [31:0] v, int n);
        t_answer a;
        a.status = st;
        a.hit = hit;
        a.value = v;
        a.count = n[6:0];
        return a;
    endfunction

    // directed stimulus; expectations typed in only where obvious
    t_row rows[$];

    task automatic add_row(logic [1:0] act, logic [31:0] key, logic [31:0] val, logic lin,
                           logic known = 1'b0, t_answer ans = '0);
        t_row r;
        r.act = act; r.key = key; r.val = val; r.lin = lin; r.known = known; r.ans = ans;
        rows = {rows, r};
    endtask

    initial begin
        t_row r;
        logic [1:0] act;
        logic [31:0] key;
        stim_done = 1'b0;
        n_fail = 0;
        bp_fill = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_row(ACT_LOOKUP, 32'd5, 32'd0, 1'b1, 1'b1, ans_of(ST_EMPTY, 0, 0, 0));
        add_row(ACT_REMOVE, 32'd5, 32'd0, 1'b0, 1'b1, ans_of(ST_NOTFOUND, 0, 0, 0));
        add_row(ACT_CLEAR, 32'd0, 32'd0, 1'b0, 1'b1, ans_of(ST_OK, 0, 0, 0));
        add_row(ACT_SET, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b1, ans_of(ST_OK, 0, 0, 1));
        add_row(ACT_SET, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b1, ans_of(ST_OK, 0, 0, 2));
        add_row(ACT_LOOKUP, 32'd0, 32'd0, 1'b1);
        add_row(ACT_LOOKUP, 32'd0, 32'd0, 1'b0, 1'b1, ans_of(ST_OK, 0, 32'h7fff_ffff, 2));
        add_row(ACT_LOOKUP, 32'h7fff_ffff, 32'd0, 1'b1,
                1'b1, ans_of(ST_OK, 1, 32'h8000_0000, 2));
        add_row(ACT_SET, 32'd100, 32'h0001_0000, 1'b0);
        add_row(ACT_SET, 32'd100, 32'hffff_0000, 1'b1, 1'b1, ans_of(ST_OK, 1, 0, 3));
        add_row(ACT_SET, 32'd300, 32'h0003_0000, 1'b0);
        add_row(ACT_LOOKUP, 32'd201, 32'd0, 1'b1);
        add_row(ACT_LOOKUP, 32'd201, 32'd0, 1'b0);
        add_row(ACT_LOOKUP, 32'hffff_fff0, 32'd0, 1'b1);
        add_row(ACT_REMOVE, 32'h8000_0000, 32'd0, 1'b0, 1'b1, ans_of(ST_OK, 1, 0, 3));
        add_row(ACT_LOOKUP, 32'h8000_0000, 32'd0, 1'b1);
        add_row(ACT_REMOVE, 32'h7fff_ffff, 32'd0, 1'b0);
        add_row(ACT_LOOKUP, 32'h7fff_ffff, 32'd0, 1'b1);
        add_row(ACT_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b1, ans_of(ST_OK, 0, 0, 0));
        foreach (rows[i]) begin
            r = rows[i];
            send_item(r.act, r.key, r.val, r.lin, r.known, r.ans);
        end
        // fill to capacity, then hit the full case
        for (int i = 0; i < Capacity; i++)
            send_item(ACT_SET, 32'(i * 7 - 200), rand_word(), 1'b0, 1'b0, '0);
        send_item(ACT_SET, 32'd1, 32'd1, 1'b0, 1'b1, ans_of(ST_FULL, 0, 0, Capacity));
        send_item(ACT_LOOKUP, 32'd3, 32'd0, 1'b1, 1'b0, '0);
        send_item(ACT_CLEAR, 32'd0, 32'd0, 1'b0, 1'b0, '0);

        // random part: mostly small key pool so hits, removes and interpolation happen
        for (int n = 0; n < RandItems; n++) begin
            case ($urandom_range(0, 19))
                0: act = ACT_CLEAR;
                1, 2, 3, 4, 5, 6, 7: act = ACT_SET;
                8, 9, 10: act = ACT_REMOVE;
                default: act = ACT_LOOKUP;
            endcase
            if (n % 300 < 60 && act == ACT_REMOVE) act = ACT_SET;
            if (n % 300 < 60 && act == ACT_CLEAR) act = ACT_SET;
            if ($urandom_range(0, 3) == 0) key = rand_word();
            else key = 32'($signed($urandom_range(0, 120)) - 60) * 1000;
            send_item(act, key, rand_word(), 1'($urandom_range(0, 1)), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // result side
    initial begin
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 4) == 0)
                m_axis_tready <= 1'b0;
            else if ($urandom_range(0, 49) == 0)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= 1'b1;
            if (!m_axis_tready && $urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(10, 50)) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (answer_q.size() == 0) begin
                $error("result beat with nothing expected");
                n_fail++;
            end else begin
                e = answer_q.pop_front();
                if (m_axis_tuser !== e.status) begin
                    $error("status: expected %0d, actual %0d", e.status, m_axis_tuser);
                    n_fail++;
                end
                if (m_axis_tdata[0] !== e.hit) begin
                    $error("exact_hit: expected %0d, actual %0d", e.hit, m_axis_tdata[0]);
                    n_fail++;
                end
                if (m_axis_tdata[32:1] !== e.value) begin
                    $error("result_value: expected %h, actual %h", e.value,
                           m_axis_tdata[32:1]);
                    n_fail++;
                end
                if (m_axis_tdata[39:33] !== e.count) begin
                    $error("points_held: expected %0d, actual %0d", e.count,
                           m_axis_tdata[39:33]);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        cycles = 0;
        while (!(stim_done && answer_q.size() == 0) && cycles < CycleLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        if (cycles >= CycleLimit) begin
            $display("tb_sorted_breakpoint_table_interp_core: FAIL");
        end else begin
            repeat (400) @(posedge i_clk);
            if (n_fail == 0 && answer_q.size() == 0)
                $display("tb_sorted_breakpoint_table_interp_core: PASS");
            else
                $display("tb_sorted_breakpoint_table_interp_core: FAIL");
        end
        $finish;
    end
endmodule

@@ files.f @@
+incdir+hdl
hdl/sbt_pkg.sv
hdl/sbt_div.sv
hdl/sbt_ctrl.sv
hdl/sorted_breakpoint_table_interp_core.sv
tb/tb_sorted_breakpoint_table_interp_core.sv
